>>> design/slst_pkg.sv
// Shared constants, types and the quarter-wave cosine table of the setpoint generator.
`timescale 1ns / 1ps

package slst_pkg;

    // Field widths.
    localparam int POS_W    = 24;
    localparam int STEP_W   = 17;
    localparam int MSTEP_W  = 16;
    localparam int AMP_W    = 20;
    localparam int PHASE_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // Cosine table geometry: one quarter wave, power-of-two depth.
    localparam int COS_TABLE_DEPTH = 256;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int COS_W           = 17;
    localparam int OMC_W           = 18;

    // Q30 value of pi/2, the argument scale of the table build.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Unity in Q16.
    localparam logic [OMC_W-1:0] COS_ONE = 18'd65536;

    // Saturation limits of the command, one bit wider than a position.
    localparam logic signed [POS_W:0] POS_MAX_W = 25'sd8388607;
    localparam logic signed [POS_W:0] POS_MIN_W = -25'sd8388608;

    // Reset values of the configuration registers.
    localparam logic [MSTEP_W-1:0] MAX_STEP_RST   = 16'd164;
    localparam logic [AMP_W-1:0]   SCAN_AMP_RST   = 20'd102944;
    localparam logic [PHASE_W-1:0] PHASE_INC_RST  = 16'd39;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_STEP  = 2'd0,
        REG_SCAN_AMP  = 2'd1,
        REG_PHASE_INC = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_reg_t;

    typedef logic [COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

    // Unsigned quotient by shift and subtract, used only while the table is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Cosine of a Q30 angle in [0, pi/2] by a Taylor series to x^20, Q16 result.
    function automatic logic [COS_W-1:0] cos_q16(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned res;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int n = 1; n <= 10; n++)
        begin
            term = (term * x2) >> 30;
            term = div_u64(term, 64'((2 * n - 1) * (2 * n)));
            if (n % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        res = (longint'(sum) + (64'd1 << 13)) >> 14;
        return res[COS_W-1:0];
    endfunction

    // Whole table, worked out at elaboration.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            rom[k] = cos_q16((HALF_PI_Q30 * longint'(k)) / COS_TABLE_DEPTH);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

>>> design/slew_limited_setpoint_scan_track_core.sv
// Slew-limited setpoint generator with cosine scan and offset tracking.
`timescale 1ns / 1ps

// One request is one servo tick and gives one result. A tick is taken into an input
// register, its goal and slew-limited command are formed in combinational logic
// (a quarter-wave table read and one 20 by 18 bit multiply), and the result lands in an
// output register. The block takes one tick per cycle while results are collected; the
// command feedback closes through the tick state register, loaded with the output register.
// The first tick after reset seeds the command with the measured position. With the track
// flag low the goal follows a cosine scan around a centre that is captured on the falling
// edge of the flag (and on a first tick with the flag low). Configuration writes are always
// taken and must only be issued while the block is idle; unknown indexes are ignored.
module slew_limited_setpoint_scan_track_core
    import slst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Tick requests
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [POS_W-1:0]   measured_pos,
    input  logic                      track_valid,
    input  logic signed [POS_W-1:0]   goal_offset,
    // Results
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [POS_W-1:0]   cmd_pos,
    output logic signed [STEP_W-1:0]  cmd_step,
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [MSTEP_W-1:0] max_step_reg;
    logic [AMP_W-1:0]   scan_amp_reg;
    logic [PHASE_W-1:0] phase_inc_reg;

    // Input stage.
    logic                    s1_vld_reg;
    logic signed [POS_W-1:0] meas_reg;
    logic                    tv_reg;
    logic signed [POS_W-1:0] offs_reg;

    // Tick state.
    logic signed [POS_W-1:0] cmd_reg;
    logic                    seeded_reg;
    logic signed [POS_W-1:0] center_reg;
    logic [PHASE_W-1:0]      phase_reg;
    logic                    prev_tv_reg;

    // Output stage.
    logic                     out_vld_reg;
    logic signed [POS_W-1:0]  cmd_pos_reg;
    logic signed [STEP_W-1:0] cmd_step_reg;

    // Datapath.
    logic                     advance;
    logic                     fire;
    logic                     restart;
    logic [PHASE_W-1:0]       phase_use;
    logic signed [POS_W-1:0]  center_use;
    logic [1:0]               quad;
    logic [COS_IDX_W-1:0]     lo_idx;
    logic [COS_IDX_W:0]       mirror_idx;
    logic [COS_IDX_W-1:0]     rd_idx;
    logic                     cos_zero;
    logic [COS_W-1:0]         cos_mag;
    logic [OMC_W-1:0]         one_minus_cos;
    logic [AMP_W+OMC_W-1:0]   scan_prod;
    logic [AMP_W+OMC_W-1:0]   scan_round;
    logic [POS_W-3:0]         scan_term;
    logic signed [POS_W+1:0]  goal;
    logic signed [POS_W-1:0]  cmd_old;
    logic signed [POS_W+2:0]  diff;
    logic signed [POS_W+2:0]  lim;
    logic signed [STEP_W-1:0] diff_c;
    logic signed [POS_W:0]    next_wide;
    logic signed [POS_W-1:0]  next_cmd;
    logic signed [STEP_W-1:0] step;

    assign cfg_ready = 1'b1;
    assign out_valid = out_vld_reg;
    assign cmd_pos   = cmd_pos_reg;
    assign cmd_step  = cmd_step_reg;

    // The input stage moves on whenever the output register is free or being emptied.
    assign advance  = !out_vld_reg || out_ready;
    assign fire     = s1_vld_reg && advance;
    assign in_ready = !s1_vld_reg || advance;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg  <= MAX_STEP_RST;
            scan_amp_reg  <= SCAN_AMP_RST;
            phase_inc_reg <= PHASE_INC_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_STEP:  max_step_reg  <= cfg_data[MSTEP_W-1:0];
                REG_SCAN_AMP:  scan_amp_reg  <= cfg_data[AMP_W-1:0];
                REG_PHASE_INC: phase_inc_reg <= cfg_data[PHASE_W-1:0];
                REG_UNUSED:    ;
                default:       ;
            endcase
        end
    end

    // Scan restart on a falling edge of the track flag.
    always_comb
    begin
        restart    = !tv_reg && prev_tv_reg;
        phase_use  = restart ? '0 : phase_reg;
        center_use = restart ? meas_reg : center_reg;
    end

    // Quarter-wave cosine lookup; the mirrored index of the full quarter reads as zero.
    always_comb
    begin
        quad       = phase_use[PHASE_W-1 -: 2];
        lo_idx     = phase_use[PHASE_W-3 -: COS_IDX_W];
        mirror_idx = (COS_IDX_W+1)'(COS_TABLE_DEPTH) - {1'b0, lo_idx};
        rd_idx     = quad[0] ? mirror_idx[COS_IDX_W-1:0] : lo_idx;
        cos_zero   = quad[0] && (lo_idx == '0);
        cos_mag    = cos_zero ? '0 : COS_ROM[rd_idx];
        if (quad[1] ^ quad[0])
        begin
            one_minus_cos = COS_ONE + {1'b0, cos_mag};
        end
        else
        begin
            one_minus_cos = COS_ONE - {1'b0, cos_mag};
        end
    end

    // Scan term, rounded half up at the Q16 point, and the goal of either mode.
    always_comb
    begin
        scan_prod  = (AMP_W+OMC_W)'(scan_amp_reg) * (AMP_W+OMC_W)'(one_minus_cos);
        scan_round = scan_prod + (AMP_W+OMC_W)'(32768);
        scan_term  = scan_round[16 +: POS_W-2];
        if (tv_reg)
        begin
            goal = (POS_W+2)'(meas_reg) + (POS_W+2)'(offs_reg);
        end
        else
        begin
            goal = (POS_W+2)'(center_use) - $signed({4'b0000, scan_term});
        end
    end

    // Slew limit and saturation of the command.
    always_comb
    begin
        cmd_old = seeded_reg ? cmd_reg : meas_reg;
        diff    = (POS_W+3)'(goal) - (POS_W+3)'(cmd_old);
        lim     = $signed({11'b0, max_step_reg});
        priority if (diff > lim)
        begin
            diff_c = STEP_W'(lim);
        end
        else if (diff < -lim)
        begin
            diff_c = STEP_W'(-lim);
        end
        else
        begin
            diff_c = STEP_W'(diff);
        end
        next_wide = (POS_W+1)'(cmd_old) + (POS_W+1)'(diff_c);
        priority if (next_wide > POS_MAX_W)
        begin
            next_cmd = POS_W'(POS_MAX_W);
        end
        else if (next_wide < POS_MIN_W)
        begin
            next_cmd = POS_W'(POS_MIN_W);
        end
        else
        begin
            next_cmd = POS_W'(next_wide);
        end
        step = STEP_W'((POS_W+1)'(next_cmd) - (POS_W+1)'(cmd_old));
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= measured_pos;
            tv_reg   <= track_valid;
            offs_reg <= goal_offset;
        end
    end

    // Tick state update as a request passes into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= '0;
            seeded_reg  <= 1'b0;
            center_reg  <= '0;
            phase_reg   <= '0;
            prev_tv_reg <= 1'b1;
        end
        else if (fire)
        begin
            cmd_reg     <= next_cmd;
            seeded_reg  <= 1'b1;
            center_reg  <= center_use;
            phase_reg   <= phase_use + phase_inc_reg;
            prev_tv_reg <= tv_reg;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cmd_pos_reg  <= next_cmd;
            cmd_step_reg <= step;
        end
    end

endmodule
